>>> rtl/qhta_pkg.sv
// Package for the hinge twist angle block: widths, constants and the arctangent table.
// Used by every module of the block; depends on nothing.
`default_nettype none
package qhta_pkg;
  localparam int CORDIC_STEPS = 14;
  localparam int CW = 64;
  localparam int ZW = 24;
  localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647100;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic [1:0] REG_AXIS_X = 2'd0;
  localparam logic [1:0] REG_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cvec_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 24'sd823550;   1: t = 24'sd486170;  2: t = 24'sd256879;
      3: t = 24'sd130396;   4: t = 24'sd65451;   5: t = 24'sd32757;
      6: t = 24'sd16383;    7: t = 24'sd8192;    8: t = 24'sd4096;
      9: t = 24'sd2048;     10: t = 24'sd1024;   11: t = 24'sd512;
      12: t = 24'sd256;     13: t = 24'sd128;    14: t = 24'sd64;
      15: t = 24'sd32;      16: t = 24'sd16;     17: t = 24'sd8;
      18: t = 24'sd4;       default: t = 24'sd2;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

>>> rtl/qhta_front.sv
// Front end: relative quaternion products and hinge projection, three stages.
// Depends on qhta_pkg.
`default_nettype none
module qhta_front import qhta_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               v_in,
  input  wire logic signed [15:0] ax, ay, az, aw, bx, by, bz, bw,
  input  wire logic               neg_in,
  input  wire logic signed [15:0] kx, ky, kz,
  output logic                    v_out,
  output cvec_t                   vec_out
);
  logic [2:0] v_r;
  logic signed [31:0] p_r [16];
  logic neg1_r, neg2_r, neg3_r;
  logic signed [34:0] rw_r, rx_r, ry_r, rz_r;
  logic signed [51:0] px_r, py_r, pz_r;
  logic signed [CW-1:0] w3_r;
  logic signed [CW-1:0] proj;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[1:0], v_in};
  end

  // stage 1: sixteen products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= aw*bw; p_r[1] <= ax*bx; p_r[2] <= ay*by; p_r[3] <= az*bz;
      p_r[4] <= aw*bx; p_r[5] <= ax*bw; p_r[6] <= ay*bz; p_r[7] <= az*by;
      p_r[8] <= aw*by; p_r[9] <= ax*bz; p_r[10] <= ay*bw; p_r[11] <= az*bx;
      p_r[12] <= aw*bz; p_r[13] <= ax*by; p_r[14] <= ay*bx; p_r[15] <= az*bw;
      neg1_r <= neg_in;
    end
  end

  // stage 2: component sums
  always_ff @(posedge clk) begin
    if (en) begin
      rw_r <= 35'(p_r[0]) + 35'(p_r[1]) + 35'(p_r[2]) + 35'(p_r[3]);
      rx_r <= 35'(p_r[4]) - 35'(p_r[5]) - 35'(p_r[6]) + 35'(p_r[7]);
      ry_r <= 35'(p_r[8]) + 35'(p_r[9]) - 35'(p_r[10]) - 35'(p_r[11]);
      rz_r <= 35'(p_r[12]) - 35'(p_r[13]) + 35'(p_r[14]) - 35'(p_r[15]);
      neg2_r <= neg1_r;
    end
  end

  // stage 3: axis products
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 52'(rx_r * kx);
      py_r <= 52'(ry_r * ky);
      pz_r <= 52'(rz_r * kz);
      w3_r <= CW'(rw_r) <<< 14;
      neg3_r <= neg2_r;
    end
  end

  assign proj = CW'(px_r) + CW'(py_r) + CW'(pz_r);
  assign v_out = v_r[2];
  assign vec_out = '{x: w3_r, y: proj, z: '0, neg: neg3_r};
endmodule
`default_nettype wire

>>> rtl/qhta_cordic.sv
// CORDIC vectoring pipeline: pre-rotation stage then one stage per step.
// Depends on qhta_pkg.
`default_nettype none
module qhta_cordic import qhta_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  v_in,
  input  cvec_t      vec_in,
  output logic       v_out,
  output cvec_t      vec_out,
  output logic       zero_y
);
  cvec_t st_r [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] v_r;
  logic [CORDIC_STEPS:0] zy_r;
  cvec_t pre;

  // one micro-rotation towards the x axis
  function automatic cvec_t rot_step(input cvec_t c, input int i);
    cvec_t n;
    n = c;
    if (c.y > 0) begin
      n.x = c.x + (c.y >>> i); n.y = c.y - (c.x >>> i); n.z = c.z + atan_q20(i);
    end else begin
      n.x = c.x - (c.y >>> i); n.y = c.y + (c.x >>> i); n.z = c.z - atan_q20(i);
    end
    return n;
  endfunction

  // quarter-turn pre-rotation for a negative scalar part;
  // zero projection carries pi or 0 in z
  always_comb begin
    pre = vec_in;
    if (vec_in.x < 0) begin
      if (vec_in.y > 0) begin
        pre.x = vec_in.y; pre.y = -vec_in.x; pre.z = HALF_PI_Q20;
      end else begin
        pre.x = -vec_in.y; pre.y = vec_in.x; pre.z = -HALF_PI_Q20;
      end
    end
    if (vec_in.y == 0) pre.z = (vec_in.x < 0) ? PI_Q20 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[CORDIC_STEPS-1:0], v_in};
  end

  // load the first stage, then advance one micro-rotation per stage;
  // a flagged zero projection passes through unchanged
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= pre;
      zy_r[0] <= (vec_in.y == 0);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        st_r[i+1] <= zy_r[i] ? st_r[i] : rot_step(st_r[i], i);
        zy_r[i+1] <= zy_r[i];
      end
    end
  end

  assign v_out = v_r[CORDIC_STEPS];
  assign vec_out = st_r[CORDIC_STEPS];
  assign zero_y = zy_r[CORDIC_STEPS];
endmodule
`default_nettype wire

>>> rtl/quaternion_hinge_twist_angle.sv
// Top level of the hinge twist angle block: config registers, pipeline, output stage.
// Depends on qhta_pkg, qhta_front and qhta_cordic.
//
//  channel | direction | handshake            | payload
//  in_     | in        | in_valid/in_ready    | qa_*, qb_*, negate
//  out_    | out       | out_valid/out_ready  | twist_angle
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One word enters per cycle while the pipeline advances. A word passes through the
// front-end stages, the CORDIC stages and the output register. The whole pipeline
// advances when the output register is empty or being taken. A stall freezes every
// stage in place. Reset clears valid bits and loads the hinge axis (0, 1.0, 0).
`default_nettype none
module quaternion_hinge_twist_angle import qhta_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_qa_x, in_qa_y, in_qa_z, in_qa_w,
  input  wire logic signed [15:0] in_qb_x, in_qb_y, in_qb_z, in_qb_w,
  input  wire logic               in_negate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_twist_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  logic signed [15:0] ax_r, ay_r, az_r;
  logic en, fv, cv, zy;
  cvec_t fvec, cvec;
  logic signed [ZW:0] a2, aw;
  logic signed [ZW:0] q;
  logic signed [15:0] res;
  logic signed [15:0] out_r;
  logic ov_r;

  assign en = !ov_r || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  // hold the hinge axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= 16'sd0; ay_r <= 16'sd16384; az_r <= 16'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AXIS_X: ax_r <= cfg_data;
        REG_AXIS_Y: ay_r <= cfg_data;
        REG_AXIS_Z: az_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qhta_front u_front (
    .clk, .rst_n, .en, .v_in(in_valid),
    .ax(in_qa_x), .ay(in_qa_y), .az(in_qa_z), .aw(in_qa_w),
    .bx(in_qb_x), .by(in_qb_y), .bz(in_qb_z), .bw(in_qb_w),
    .neg_in(in_negate), .kx(ax_r), .ky(ay_r), .kz(az_r),
    .v_out(fv), .vec_out(fvec)
  );

  qhta_cordic u_cordic (
    .clk, .rst_n, .en, .v_in(fv), .vec_in(fvec),
    .v_out(cv), .vec_out(cvec), .zero_y(zy)
  );

  // double (zero for a zero projection), wrap, round, clamp and negate
  always_comb begin
    a2 = (ZW+1)'(cvec.z) <<< 1;
    if (zy) a2 = '0;
    aw = a2;
    if (a2 > (ZW+1)'(PI_Q20)) aw = a2 - ((ZW+1)'(PI_Q20) <<< 1);
    else if (a2 < -(ZW+1)'(PI_Q20)) aw = a2 + ((ZW+1)'(PI_Q20) <<< 1);
    q = (aw + (ZW+1)'(64)) >>> 7;
    if (q > (ZW+1)'(PI_Q13)) q = (ZW+1)'(PI_Q13);
    if (q < -(ZW+1)'(PI_Q13)) q = -(ZW+1)'(PI_Q13);
    res = cvec.neg ? -q[15:0] : q[15:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= cv;
  end
  always_ff @(posedge clk) begin
    if (en) out_r <= res;
  end

  assign out_valid = ov_r;
  assign out_twist_angle = out_r;
endmodule
`default_nettype wire

>>> rtl/qhta_checker.sv
// Port-level checker for the hinge twist angle block, bound to the top level.
// Depends on qhta_pkg.
`default_nettype none
module qhta_checker import qhta_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_twist_angle
);
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_twist_angle <= PI_Q13 && out_twist_angle >= -PI_Q13))
    else $error("angle out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_twist_angle))
    else $error("stalled word changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready not tied to output stage");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind quaternion_hinge_twist_angle qhta_checker u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_twist_angle
);
`default_nettype wire

>>> verif/testbench.sv
// Testbench for quaternion_hinge_twist_angle: directed and random quaternion pairs,
// hinge axis settings and random idling on both channels. Depends on qhta_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import qhta_pkg::*;

  localparam longint PI_Q20_L = 3294199;
  localparam longint HALF_PI_L = 1647100;
  localparam longint PI_Q13_L = 25736;
  localparam int STEPS = CORDIC_STEPS;
  localparam int LATENCY = 3 + 1 + CORDIC_STEPS + 1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_qa_x, in_qa_y, in_qa_z, in_qa_w;
  logic signed [15:0] in_qb_x, in_qb_y, in_qb_z, in_qb_w;
  logic in_negate;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_twist_angle;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  // hinge axis as the predictor sees it
  logic signed [15:0] hinge_x, hinge_y, hinge_z;
  logic signed [15:0] angle_queue[$];
  int errors;
  int words_sent;
  int angles_seen;

  quaternion_hinge_twist_angle uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_qa_x(in_qa_x), .in_qa_y(in_qa_y), .in_qa_z(in_qa_z), .in_qa_w(in_qa_w),
    .in_qb_x(in_qb_x), .in_qb_y(in_qb_y), .in_qb_z(in_qb_z), .in_qb_w(in_qb_w),
    .in_negate(in_negate),
    .out_valid(out_valid), .out_ready(out_ready), .out_twist_angle(out_twist_angle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("quaternion_hinge_twist_angle verification failed");
    $finish;
  end

  // floor division by a power of two
  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  // vectoring CORDIC, Q.20 radians
  function automatic longint cordic_angle(input longint y_in, input longint x_in);
    longint x, y, z, t, dx, dy;
    x = x_in;
    y = y_in;
    z = 0;
    if (y == 0) return (x < 0) ? PI_Q20_L : 0;
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = HALF_PI_L;
      end else begin
        x = -y; y = t; z = -HALF_PI_L;
      end
    end
    for (int i = 0; i < STEPS && i < 20; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_q20(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q20(i));
      end
    end
    return z;
  endfunction

  function automatic logic signed [15:0] twist_of(
      input logic signed [15:0] ax, ay, az, aw, bx, by, bz, bw, input logic neg);
    longint rw, rx, ry, rz, proj, ang;
    rw = aw * bw + ax * bx + ay * by + az * bz;
    rx = longint'(aw) * bx - longint'(ax) * bw - longint'(ay) * bz + longint'(az) * by;
    ry = longint'(aw) * by + longint'(ax) * bz - longint'(ay) * bw - longint'(az) * bx;
    rz = longint'(aw) * bz - longint'(ax) * by + longint'(ay) * bx - longint'(az) * bw;
    rw = longint'(aw) * bw + longint'(ax) * bx + longint'(ay) * by + longint'(az) * bz;
    proj = rx * longint'(hinge_x) + ry * longint'(hinge_y) + rz * longint'(hinge_z);
    ang = 2 * cordic_angle(proj, rw * 16384);
    if (ang > PI_Q20_L) ang -= 2 * PI_Q20_L;
    else if (ang < -PI_Q20_L) ang += 2 * PI_Q20_L;
    ang = floor_shift(ang + 64, 7);
    if (ang > PI_Q13_L) ang = PI_Q13_L;
    if (ang < -PI_Q13_L) ang = -PI_Q13_L;
    if (neg) ang = -ang;
    return ang[15:0];
  endfunction

  // send one quaternion pair, after a random gap when gaps is set; valid stays high
  // between back-to-back words and is dropped only for a gap or by drain
  task automatic send_pair(input logic [15:0] ax, ay, az, aw, bx, by, bz, bw,
                           input logic neg, input bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_qa_x <= ax; in_qa_y <= ay; in_qa_z <= az; in_qa_w <= aw;
    in_qb_x <= bx; in_qb_y <= by; in_qb_z <= bz; in_qb_w <= bw;
    in_negate <= neg;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angle_queue.push_back(twist_of(ax, ay, az, aw, bx, by, bz, bw, neg));
    words_sent++;
    @(negedge clk);
  endtask

  // wait until every angle is back, then let the pipeline empty
  task automatic drain;
    in_valid <= 1'b0;
    while (angle_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_axis(input logic [1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_AXIS_X: hinge_x = val;
      REG_AXIS_Y: hinge_y = val;
      REG_AXIS_Z: hinge_z = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_axis(input logic [15:0] x, y, z);
    drain();
    write_axis(REG_AXIS_X, x);
    write_axis(REG_AXIS_Y, y);
    write_axis(REG_AXIS_Z, z);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp;
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // field extremes, identity, half turn, zero projection, both zero
  task automatic test_directed;
    send_pair(0, 0, 0, 16384, 0, 0, 0, 16384, 0);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_pair(0, 0, 0, 16384, 0, 16384, 0, 0, 0);
    send_pair(0, 0, 0, 16384, 0, 16384, 0, 0, 1);
    send_pair(0, 0, 0, 16384, 0, 11585, 0, 11585, 0);
    send_pair(0, 0, 0, 16384, 0, -11585, 0, -11585, 0);
    send_pair(0, 0, 0, 16384, 0, 0, 0, -16384, 0);
    send_pair(0, 0, 0, 16384, 0, 100, 0, -16384, 0);
    send_pair(0, 0, 0, 16384, 0, -100, 0, -16384, 1);
    send_pair(0, 0, 0, 16384, 16384, 0, 0, 0, 0);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 0);
    send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 1);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 1);
    send_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
              16'h5555, 0);
    send_pair(0, 16'h8000, 0, 0, 0, 0, 0, 16'h7FFF, 0);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++)
      send_pair(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                1'($urandom_range(0, 1)));
  endtask

  // back-to-back words to fill the pipeline
  task automatic test_burst(input int count);
    for (int n = 0; n < count; n++)
      send_pair(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                1'($urandom_range(0, 1)), 1'b0);
  endtask

  // accept and check each angle
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        angles_seen++;
        if (angle_queue.size() == 0) begin
          $display("%0t: unexpected angle, expected none, actual %0d", $time,
                   out_twist_angle);
          errors++;
        end else if (angle_queue[0] !== out_twist_angle) begin
          $display("%0t: twist_angle mismatch, expected %0d, actual %0d", $time,
                   angle_queue[0], out_twist_angle);
          errors++;
          void'(angle_queue.pop_front());
        end else begin
          void'(angle_queue.pop_front());
        end
      end
    end
  end

  // receiver stalls: a random wait before each word, with calm stretches
  initial begin
    int wait_cycles;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    angles_seen = 0;
    hinge_x = 0;
    hinge_y = 16384;
    hinge_z = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_qa_x = 0; in_qa_y = 0; in_qa_z = 0; in_qa_w = 0;
    in_qb_x = 0; in_qb_y = 0; in_qb_z = 0; in_qb_w = 0;
    in_negate = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_AXIS_X;
    cfg_data = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(150);
    set_axis(16384, 0, 0);
    test_directed();
    test_random(150);
    set_axis(16'h7FFF, 16'h7FFF, 16'h7FFF);
    test_random(150);
    set_axis(16'h8000, 16'h8000, 16'h8000);
    test_random(150);
    set_axis(0, 0, 0);
    test_random(30);
    set_axis(0, 0, 16384);
    test_burst(60);
    drain();
    set_axis(16'($urandom), 16'($urandom), 16'($urandom));
    test_random(200);

    drain();
    $display("Sent %0d quaternion pairs over seven hinge axes, %0d angles checked.",
             words_sent, angles_seen);
    $display("Axis extremes, zero axis, half turns and back-to-back bursts covered.");
    if (errors == 0 && angle_queue.size() == 0) begin
      $display("quaternion_hinge_twist_angle verification clean");
    end else begin
      $display("quaternion_hinge_twist_angle verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> quaternion_hinge_twist_angle.f
rtl/qhta_pkg.sv
rtl/qhta_front.sv
rtl/qhta_cordic.sv
rtl/quaternion_hinge_twist_angle.sv
rtl/qhta_checker.sv
verif/testbench.sv
